>>> hw/rtl/xsr_pkg.sv
// ----------------------------------------------------------------------------
// xsr_pkg
// Shared types and constants for the xoshiro256** generator with splitmix64
// seeding.
// ----------------------------------------------------------------------------
package xsr_pkg;

    localparam int WORD_W  = 64;
    localparam int HALF_W  = 32;
    localparam int BOUND_W = 32;
    localparam int OP_W    = 2;
    localparam int N_WORDS = 4;
    localparam int IDX_W   = 2;
    localparam int CNT_W   = 6;

    localparam logic [OP_W-1:0] OP_SEED    = 2'd0;
    localparam logic [OP_W-1:0] OP_NEXT    = 2'd1;
    localparam logic [OP_W-1:0] OP_BOUNDED = 2'd2;

    localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
    localparam logic [WORD_W-1:0] MIX_MUL_A    = 64'hbf58476d1ce4e5b9;
    localparam logic [WORD_W-1:0] MIX_MUL_B    = 64'h94d049bb133111eb;
    localparam int SHIFT_T = 17;
    localparam int ROT_S3  = 45;
    localparam int ROT_OUT = 7;

    localparam logic [IDX_W-1:0] LAST_WORD = IDX_W'(N_WORDS - 1);

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [WORD_W-1:0]  seed_value;
        logic [BOUND_W-1:0] bound;
    } in_beat_t;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              bound_error;
    } out_beat_t;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] product;
    } mul_rsp_t;

    typedef struct packed {
        logic               start;
        logic [WORD_W-1:0]  dividend;
        logic [BOUND_W-1:0] divisor;
    } mod_req_t;

    typedef struct packed {
        logic               done;
        logic [BOUND_W-1:0] remainder;
    } mod_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX_A,
        ST_WAIT_A,
        ST_MIX_B,
        ST_WAIT_B,
        ST_MOD,
        ST_OUT
    } state_t;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int amt);
        logic [2*WORD_W-1:0] w;
        w = {v, v} << amt;
        return w[2*WORD_W-1:WORD_W];
    endfunction

endpackage

>>> hw/rtl/xsr_mul.sv
// ----------------------------------------------------------------------------
// xsr_mul
// Iterative 64-bit multiplier returning the low 64 bits of the product. One
// 32x32 multiplier is reused in turn for the three partial products.
// ----------------------------------------------------------------------------
module xsr_mul
    import xsr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic [WORD_W-1:0] a_reg, a_next;
    logic [WORD_W-1:0] b_reg, b_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [1:0]        step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [HALF_W-1:0] mx;
    logic [HALF_W-1:0] my;
    logic [WORD_W-1:0] pp;

    always_comb
    begin
        mx = (step_reg == 2'd2) ? a_reg[WORD_W-1:HALF_W] : a_reg[HALF_W-1:0];
        my = (step_reg == 2'd1) ? b_reg[WORD_W-1:HALF_W] : b_reg[HALF_W-1:0];
        pp = WORD_W'(mx) * WORD_W'(my);
    end

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            a_next    = req.a;
            b_next    = req.b;
            step_next = 2'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            case (step_reg)
                2'd0:
                begin
                    acc_next  = pp;
                    step_next = 2'd1;
                end
                2'd1:
                begin
                    acc_next[WORD_W-1:HALF_W] = acc_reg[WORD_W-1:HALF_W] + pp[HALF_W-1:0];
                    step_next = 2'd2;
                end
                default:
                begin
                    acc_next[WORD_W-1:HALF_W] = acc_reg[WORD_W-1:HALF_W] + pp[HALF_W-1:0];
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 2'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

>>> hw/rtl/xsr_mod.sv
// ----------------------------------------------------------------------------
// xsr_mod
// Bit-serial remainder unit: 64-bit dividend modulo a nonzero 32-bit divisor,
// one restoring compare and subtract per cycle.
// ----------------------------------------------------------------------------
module xsr_mod
    import xsr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mod_req_t req,
    output mod_rsp_t rsp
);

    logic [WORD_W-1:0]  x_reg, x_next;
    logic [BOUND_W-1:0] d_reg, d_next;
    logic [BOUND_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [BOUND_W:0]   trial;
    logic [BOUND_W:0]   diff;

    always_comb
    begin
        trial = {rem_reg, x_reg[WORD_W-1]};
        diff  = trial - {1'b0, d_reg};
    end

    always_comb
    begin
        x_next    = x_reg;
        d_next    = d_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            x_next    = req.dividend;
            d_next    = req.divisor;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = (trial >= {1'b0, d_reg}) ? diff[BOUND_W-1:0] : trial[BOUND_W-1:0];
            x_next   = x_reg << 1;
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(WORD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        d_reg   <= d_next;
        rem_reg <= rem_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

>>> hw/rtl/xoshiro256ss_prng_top.sv
// ----------------------------------------------------------------------------
// xoshiro256ss_prng_top
// xoshiro256** generator with splitmix64 seeding, raw and bounded outputs.
//
//   Channel  Direction  Beat        Handshake
//   in       to block   in_beat_t   in_valid / in_stall
//   out      from block out_beat_t  out_valid / out_stall
//
// A raw next command goes from idle to the output state. A bounded command
// first waits in the remainder state on the bit-serial remainder unit (one
// bit per cycle); a zero bound goes straight to the output state. A seed
// command runs eight 64-bit multiplies on the shared multiplier, each a
// start state and a wait state. The input stays stalled until the block is
// back in idle. After reset the state is all zero. A stalled output holds
// its beat; a finished result waits in the last state until the output
// register is free.
// ----------------------------------------------------------------------------
module xoshiro256ss_prng_top
    import xsr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_beat_t out_data
);

    state_t            state_reg, state_next;
    logic [WORD_W-1:0] s_reg [N_WORDS];
    logic [WORD_W-1:0] s_next [N_WORDS];
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [WORD_W-1:0] z_reg, z_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [WORD_W-1:0] res_reg, res_next;
    logic              err_reg, err_next;
    logic              out_valid_reg, out_valid_next;
    out_beat_t         out_data_reg, out_data_next;

    mul_req_t          mul_req;
    mul_rsp_t          mul_rsp;
    mod_req_t          mod_req;
    mod_rsp_t          mod_rsp;

    logic [WORD_W-1:0] adv_s [N_WORDS];
    logic [WORD_W-1:0] adv_out;
    logic [WORD_W-1:0] mul5;
    logic [WORD_W-1:0] rot7;
    logic [WORD_W-1:0] mix_word;
    logic              out_free;

    xsr_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    xsr_mod u_mod
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    always_comb
    begin
        logic [WORD_W-1:0] t2;
        logic [WORD_W-1:0] t3;
        mul5     = s_reg[1] + (s_reg[1] << 2);
        rot7     = rotl(mul5, ROT_OUT);
        adv_out  = rot7 + (rot7 << 3);
        t2       = s_reg[2] ^ s_reg[0];
        t3       = s_reg[3] ^ s_reg[1];
        adv_s[1] = s_reg[1] ^ t2;
        adv_s[0] = s_reg[0] ^ t3;
        adv_s[2] = t2 ^ (s_reg[1] << SHIFT_T);
        adv_s[3] = rotl(t3, ROT_S3);
        mix_word = mul_rsp.product ^ (mul_rsp.product >> 31);
        out_free = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_data.op)
                        OP_SEED:    state_next = ST_MIX_A;
                        OP_NEXT:    state_next = ST_OUT;
                        OP_BOUNDED: state_next = (in_data.bound == '0) ? ST_OUT : ST_MOD;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MIX_A:  state_next = ST_WAIT_A;
            ST_WAIT_A: state_next = mul_rsp.done ? ST_MIX_B : ST_WAIT_A;
            ST_MIX_B:  state_next = ST_WAIT_B;
            ST_WAIT_B:
            begin
                if (mul_rsp.done)
                begin
                    state_next = (idx_reg == LAST_WORD) ? ST_IDLE : ST_MIX_A;
                end
            end
            ST_MOD:    state_next = mod_rsp.done ? ST_OUT : ST_MOD;
            ST_OUT:    state_next = out_free ? ST_IDLE : ST_OUT;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall         = (state_reg != ST_IDLE);
        mul_req.start    = (state_reg == ST_MIX_A) || (state_reg == ST_MIX_B);
        mul_req.a        = (state_reg == ST_MIX_A) ? (acc_reg ^ (acc_reg >> 30))
                                                   : (z_reg ^ (z_reg >> 27));
        mul_req.b        = (state_reg == ST_MIX_A) ? MIX_MUL_A : MIX_MUL_B;
        mod_req.start    = (state_reg == ST_IDLE) && in_valid
                           && (in_data.op == OP_BOUNDED) && (in_data.bound != '0);
        mod_req.dividend = adv_out;
        mod_req.divisor  = in_data.bound;
    end

    always_comb
    begin
        s_next         = s_reg;
        acc_next       = acc_reg;
        z_next         = z_reg;
        idx_next       = idx_reg;
        res_next       = res_reg;
        err_next       = err_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_data.op)
                        OP_SEED:
                        begin
                            acc_next = in_data.seed_value + GOLDEN_GAMMA;
                            idx_next = '0;
                        end
                        OP_NEXT:
                        begin
                            s_next   = adv_s;
                            res_next = adv_out;
                            err_next = 1'b0;
                        end
                        OP_BOUNDED:
                        begin
                            s_next   = adv_s;
                            res_next = '0;
                            err_next = (in_data.bound == '0);
                        end
                        default:
                        begin
                            res_next = res_reg;
                        end
                    endcase
                end
            end
            ST_WAIT_A:
            begin
                if (mul_rsp.done)
                begin
                    z_next = mul_rsp.product;
                end
            end
            ST_WAIT_B:
            begin
                if (mul_rsp.done)
                begin
                    s_next[idx_reg] = mix_word;
                    acc_next        = acc_reg + GOLDEN_GAMMA;
                    idx_next        = idx_reg + IDX_W'(1);
                end
            end
            ST_MOD:
            begin
                if (mod_rsp.done)
                begin
                    res_next = {{(WORD_W-BOUND_W){1'b0}}, mod_rsp.remainder};
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_data_next.value       = res_reg;
                    out_data_next.bound_error = err_reg;
                    out_valid_next            = 1'b1;
                end
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            for (int i = 0; i < N_WORDS; i++)
            begin
                s_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            s_reg         <= s_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        z_reg        <= z_next;
        res_reg      <= res_next;
        err_reg      <= err_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> hw/rtl/xsr_checker.sv
// ----------------------------------------------------------------------------
// xsr_checker
// Port-level checks for the generator top level, attached by bind.
// ----------------------------------------------------------------------------
module xsr_checker
    import xsr_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input in_beat_t  in_data,
    input logic      out_valid,
    input logic      out_stall,
    input out_beat_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("Stalled output beat changed.");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.bound_error |-> out_data.value == '0)
        else $error("Bound error beat carries a nonzero value.");

    a_seed_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.op == OP_SEED |=> in_stall)
        else $error("Seed command did not hold off the input.");

    a_next_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (in_data.op == OP_NEXT || in_data.op == OP_BOUNDED)
        |=> in_stall)
        else $error("Generate command did not hold off the input.");

endmodule

bind xoshiro256ss_prng_top xsr_checker u_xsr_checker (.*);

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the xoshiro256** generator with splitmix64 seeding.
// A scoreboard keeps its own copy of the four state words, predicts every raw
// and bounded result from the commands that the block accepts, and compares
// each output beat field by field. Directed commands cover the unseeded state,
// zero and extreme bounds, extreme seeds and the undefined opcode. Random
// commands follow, mostly seeded runs of next and bounded requests. Both
// handshake sides idle at random, except for one stretch with no idling.
// ----------------------------------------------------------------------------
module testbench
    import xsr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [OP_W-1:0] OP_UNDEFINED = 2'd3;
    localparam int RANDOM_ITEMS = 800;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 150;

    class prng_scoreboard;
        logic [WORD_W-1:0] gen_word [N_WORDS];
        out_beat_t pending_outputs [$];
        int mismatches;
        int seeds;
        int raws;
        int bounded;
        int zero_bounds;
        int ignored;
        int results_seen;

        function new();
            for (int i = 0; i < N_WORDS; i++)
            begin
                gen_word[i] = '0;
            end
            mismatches   = 0;
            seeds        = 0;
            raws         = 0;
            bounded      = 0;
            zero_bounds  = 0;
            ignored      = 0;
            results_seen = 0;
        endfunction

        function logic [WORD_W-1:0] rot_word(logic [WORD_W-1:0] v, int n);
            return (v << n) | (v >> (WORD_W - n));
        endfunction

        function logic [WORD_W-1:0] mix_word(logic [WORD_W-1:0] acc);
            logic [WORD_W-1:0] z;
            z = acc;
            z = (z ^ (z >> 30)) * MIX_MUL_A;
            z = (z ^ (z >> 27)) * MIX_MUL_B;
            return z ^ (z >> 31);
        endfunction

        function logic [WORD_W-1:0] advance_generator();
            logic [WORD_W-1:0] raw;
            logic [WORD_W-1:0] t;
            raw = rot_word(gen_word[1] * 64'd5, 7) * 64'd9;
            t = gen_word[1] << SHIFT_T;
            gen_word[2] ^= gen_word[0];
            gen_word[3] ^= gen_word[1];
            gen_word[1] ^= gen_word[2];
            gen_word[0] ^= gen_word[3];
            gen_word[2] ^= t;
            gen_word[3] = rot_word(gen_word[3], ROT_S3);
            return raw;
        endfunction

        function void note_command(in_beat_t b);
            out_beat_t e;
            logic [WORD_W-1:0] acc;
            logic [WORD_W-1:0] raw;
            case (b.op)
                OP_SEED:
                begin
                    acc = b.seed_value;
                    for (int i = 0; i < N_WORDS; i++)
                    begin
                        acc = acc + GOLDEN_GAMMA;
                        gen_word[i] = mix_word(acc);
                    end
                    seeds++;
                end
                OP_NEXT:
                begin
                    e.value = advance_generator();
                    e.bound_error = 1'b0;
                    pending_outputs = {pending_outputs, e};
                    raws++;
                end
                OP_BOUNDED:
                begin
                    raw = advance_generator();
                    if (b.bound == '0)
                    begin
                        e.value = '0;
                        e.bound_error = 1'b1;
                        zero_bounds++;
                    end
                    else
                    begin
                        e.value = raw % {{(WORD_W-BOUND_W){1'b0}}, b.bound};
                        e.bound_error = 1'b0;
                    end
                    pending_outputs = {pending_outputs, e};
                    bounded++;
                end
                default:
                begin
                    ignored++;
                end
            endcase
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(out_beat_t got);
            out_beat_t want;
            results_seen++;
            if (pending_outputs.size() == 0)
            begin
                report($sformatf("unexpected beat value=%h bound_error=%b",
                                 got.value, got.bound_error));
            end
            else
            begin
                want = pending_outputs.pop_front();
                if (got.value !== want.value)
                    report($sformatf("result %0d value %h, predicted %h",
                                     results_seen, got.value, want.value));
                if (got.bound_error !== want.bound_error)
                    report($sformatf("result %0d bound_error %b, predicted %b",
                                     results_seen, got.bound_error, want.bound_error));
            end
        endtask
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_beat_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_beat_t out_data;

    prng_scoreboard sb = new();
    bit calm;
    int cycles;

    xoshiro256ss_prng_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n || calm)
            out_stall = 1'b0;
        else
            out_stall = ($urandom_range(0, 99) < 33);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
    end

    function automatic in_beat_t make_beat(logic [OP_W-1:0] op, logic [WORD_W-1:0] seed,
                                           logic [BOUND_W-1:0] bound);
        in_beat_t b;
        b.op = op;
        b.seed_value = seed;
        b.bound = bound;
        return b;
    endfunction

    function automatic logic [WORD_W-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [BOUND_W-1:0] random_bound();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 32'd1;
            2: return '1;
            3, 4: return BOUND_W'($urandom_range(2, 16));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_beat(in_beat_t b);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 33)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data = b;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_command(b);
    endtask

    task automatic send_random_beat();
        int pick;
        logic [OP_W-1:0] op;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            op = OP_SEED;
        else if (pick < 50)
            op = OP_NEXT;
        else if (pick < 95)
            op = OP_BOUNDED;
        else
            op = OP_UNDEFINED;
        send_beat(make_beat(op, random_word(), random_bound()));
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        calm = 1'b0;
        cycles = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // An unseeded generator must return zeros, and must still flag a zero bound.
        send_beat(make_beat(OP_NEXT, '1, '1));
        send_beat(make_beat(OP_BOUNDED, '1, '0));
        send_beat(make_beat(OP_BOUNDED, '0, 32'd5));
        send_beat(make_beat(OP_UNDEFINED, '1, '1));
        send_beat(make_beat(OP_NEXT, '0, '0));
        send_beat(make_beat(OP_SEED, '0, '0));
        send_beat(make_beat(OP_NEXT, '0, '0));
        send_beat(make_beat(OP_BOUNDED, '0, 32'd1));
        send_beat(make_beat(OP_BOUNDED, '0, '1));
        send_beat(make_beat(OP_BOUNDED, '0, '0));
        send_beat(make_beat(OP_SEED, '1, '1));
        send_beat(make_beat(OP_NEXT, '1, '1));
        send_beat(make_beat(OP_UNDEFINED, '0, '0));
        send_beat(make_beat(OP_NEXT, '1, '1));
        send_beat(make_beat(OP_BOUNDED, '1, 32'h8000_0000));
        send_beat(make_beat(OP_BOUNDED, '1, 32'd2));
        send_beat(make_beat(OP_SEED, 64'h8000_0000_0000_0001, '0));
        send_beat(make_beat(OP_BOUNDED, '0, 32'h7fff_ffff));
        send_beat(make_beat(OP_NEXT, '0, '0));
        send_beat(make_beat(OP_SEED, random_word(), $urandom));
        send_beat(make_beat(OP_BOUNDED, random_word(), 32'd3));
        send_beat(make_beat(OP_NEXT, random_word(), $urandom));

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm = (n >= 300 && n < 450);
            send_random_beat();
        end
        calm = 1'b0;
        @(negedge clk);
        in_valid = 1'b0;

        while (sb.pending_outputs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.pending_outputs.size() != 0)
            sb.report($sformatf("%0d predicted results never arrived",
                                sb.pending_outputs.size()));

        $display("Covered %0d seeds, %0d raw draws, %0d bounded draws (%0d zero bounds),",
                 sb.seeds, sb.raws, sb.bounded, sb.zero_bounds);
        $display("%0d ignored opcodes and %0d checked results in %0d cycles.",
                 sb.ignored, sb.results_seen, cycles);
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
